// ===== sv/mmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_pkg: shared types and constants of the measure memo cache
// Operation and status codes, FNV-1a constants and fixed field widths.
// ----------------------------------------------------------------------------
package mmc_pkg;

  localparam int BYTE_W  = 8;
  localparam int SIZE_W  = 7;
  localparam int WIDTH_W = 16;
  localparam int HASH_W  = 32;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_FILL  = 2'd1,
    OP_INVAL = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_HIT  = 2'd0,
    STAT_MISS = 2'd1,
    STAT_LONG = 2'd2
  } status_t;

endpackage

// ===== sv/mmc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/measure_memo_cache_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// measure_memo_cache_top: direct-mapped memo cache for text widths
// Keys stream in a byte per beat; FNV-1a hash picks a slot, hit/miss/too long.
// ----------------------------------------------------------------------------
// Each key byte is folded into the hash in the single shared 32-bit FNV
// multiplier. After a last byte a too-long key goes straight to the result;
// else the size is folded through the same multiplier, the slot is read and
// one stored byte is compared per cycle through the key RAM read port until
// a mismatch or the end, the result then waiting for the result register to
// drain if needed. A fill copies one key byte per cycle from the key buffer
// into the key RAM. After reset and after every invalidate, a clearing pass
// walks the slot RAM; no beat is taken meanwhile. SLOTS must be a power of two.
module measure_memo_cache_top #(
  parameter int SLOTS     = 4096,
  parameter int KEY_BYTES = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_operation,
  input  logic [mmc_pkg::BYTE_W-1:0]      in_key_byte,
  input  logic                            in_last_byte,
  input  logic [mmc_pkg::SIZE_W-1:0]      in_font_size,
  input  logic signed [mmc_pkg::WIDTH_W-1:0] in_fill_width,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic signed [mmc_pkg::WIDTH_W-1:0] out_width
);

  import mmc_pkg::*;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int BUF_LEN = KEY_BYTES - 1;
  localparam int LEN_W   = $clog2(KEY_BYTES);
  localparam int KL_W    = $clog2(KEY_BYTES + 1);
  localparam int META_W  = 1 + SIZE_W + LEN_W + WIDTH_W;
  localparam int KADDR_W = SLOT_W + LEN_W;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_FOLD    = 8'b0000_0010,
    ST_HASH_SZ = 8'b0000_0100,
    ST_LOOKUP  = 8'b0000_1000,
    ST_CMP     = 8'b0001_0000,
    ST_COPY    = 8'b0010_0000,
    ST_CLEAR   = 8'b0100_0000,
    ST_EMIT    = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [HASH_W-1:0]   hash_r, hash_nxt;
  logic [KL_W-1:0]     key_len_r, key_len_nxt;
  logic                pend_r, pend_nxt;
  logic [SLOT_W-1:0]   pend_slot_r, pend_slot_nxt;
  logic [SIZE_W-1:0]   pend_size_r, pend_size_nxt;
  logic [LEN_W-1:0]    pend_len_r, pend_len_nxt;
  logic [LEN_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic [SLOT_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic                last_r, last_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [WIDTH_W-1:0]  res_width_r, res_width_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [WIDTH_W-1:0]  out_width_r, out_width_nxt;

  // shared fold unit
  logic [BYTE_W-1:0]   fold_opnd;
  logic [HASH_W-1:0]   fold_x;
  logic [HASH_W-1:0]   fold_prod;

  // memories
  logic                meta_we;
  logic [SLOT_W-1:0]   meta_waddr;
  logic [META_W-1:0]   meta_wdata;
  logic [META_W-1:0]   meta_rdata;
  logic                key_we;
  logic [KADDR_W-1:0]  key_waddr;
  logic [BYTE_W-1:0]   key_rdata;
  logic                buf_we;
  logic [BYTE_W-1:0]   buf_rdata;
  logic [LEN_W-1:0]    rd_idx;

  logic                meta_valid;
  logic [SIZE_W-1:0]   meta_size;
  logic [LEN_W-1:0]    meta_len;
  logic [WIDTH_W-1:0]  meta_width;
  logic                meta_ok;
  logic                in_fire;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign fold_opnd = (state_r == ST_HASH_SZ) ? {1'b0, size_r} : byte_r;
  assign fold_x    = hash_r ^ {{(HASH_W - BYTE_W){1'b0}}, fold_opnd};
  assign fold_prod = fold_x * FNV_PRIME;

  // read index runs one ahead of the byte being checked or copied
  assign rd_idx = (state_r == ST_IDLE || state_r == ST_LOOKUP) ? '0 :
                  LEN_W'(cmp_idx_r + 1'b1);

  assign meta_valid = meta_rdata[META_W-1];
  assign meta_size  = meta_rdata[META_W-2 -: SIZE_W];
  assign meta_len   = meta_rdata[WIDTH_W +: LEN_W];
  assign meta_width = meta_rdata[WIDTH_W-1:0];
  assign meta_ok    = meta_valid && (meta_size == size_r) && (meta_len == len_r);

  assign key_waddr  = {pend_slot_r, cmp_idx_r};

  mmc_ram #(.WIDTH(META_W), .DEPTH(SLOTS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (slot_r),
    .rdata (meta_rdata)
  );

  mmc_ram #(.WIDTH(BYTE_W), .DEPTH(SLOTS << LEN_W)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (buf_rdata),
    .raddr ({slot_r, rd_idx}),
    .rdata (key_rdata)
  );

  mmc_ram #(.WIDTH(BYTE_W), .DEPTH(1 << LEN_W)) u_buf_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (key_len_r[LEN_W-1:0]),
    .wdata (in_key_byte),
    .raddr (rd_idx),
    .rdata (buf_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    hash_nxt       = hash_r;
    key_len_nxt    = key_len_r;
    pend_nxt       = pend_r;
    pend_slot_nxt  = pend_slot_r;
    pend_size_nxt  = pend_size_r;
    pend_len_nxt   = pend_len_r;
    cmp_idx_nxt    = cmp_idx_r;
    clr_idx_nxt    = clr_idx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    byte_nxt       = byte_r;
    last_nxt       = last_r;
    size_nxt       = size_r;
    slot_nxt       = slot_r;
    len_nxt        = len_r;
    res_status_nxt = res_status_r;
    res_width_nxt  = res_width_r;
    out_status_nxt = out_status_r;
    out_width_nxt  = out_width_r;
    meta_we        = 1'b0;
    meta_waddr     = clr_idx_r;
    meta_wdata     = '0;
    key_we         = 1'b0;
    buf_we         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (op_t'(in_operation))
            OP_KEY: begin
              if (key_len_r == '0) begin
                pend_nxt = 1'b0;
              end
              buf_we = (key_len_r < KL_W'(BUF_LEN));
              if (key_len_r < KL_W'(KEY_BYTES)) begin
                key_len_nxt = KL_W'(key_len_r + 1'b1);
              end
              byte_nxt  = in_key_byte;
              last_nxt  = in_last_byte;
              size_nxt  = in_font_size;
              state_nxt = ST_FOLD;
            end
            OP_FILL: begin
              if (pend_r) begin
                meta_we     = 1'b1;
                meta_waddr  = pend_slot_r;
                meta_wdata  = {1'b1, pend_size_r, pend_len_r, in_fill_width};
                pend_nxt    = 1'b0;
                cmp_idx_nxt = '0;
                state_nxt   = ST_COPY;
              end
            end
            OP_INVAL: begin
              pend_nxt    = 1'b0;
              clr_idx_nxt = '0;
              state_nxt   = ST_CLEAR;
            end
            OP_NONE: begin
              state_nxt = ST_IDLE;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_FOLD: begin
        hash_nxt = fold_prod;
        len_nxt  = key_len_r[LEN_W-1:0];
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (key_len_r >= KL_W'(KEY_BYTES)) begin
          hash_nxt       = FNV_BASIS;
          key_len_nxt    = '0;
          pend_nxt       = 1'b0;
          res_status_nxt = STAT_LONG;
          res_width_nxt  = '0;
          state_nxt      = ST_EMIT;
        end else begin
          state_nxt = ST_HASH_SZ;
        end
      end
      ST_HASH_SZ: begin
        slot_nxt    = fold_prod[SLOT_W-1:0];
        hash_nxt    = FNV_BASIS;
        key_len_nxt = '0;
        state_nxt   = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmp_idx_nxt = '0;
        state_nxt   = ST_CMP;
      end
      ST_CMP: begin
        if (!meta_ok || (cmp_idx_r != len_r && key_rdata != buf_rdata)) begin
          pend_nxt       = 1'b1;
          pend_slot_nxt  = slot_r;
          pend_size_nxt  = size_r;
          pend_len_nxt   = len_r;
          res_status_nxt = STAT_MISS;
          res_width_nxt  = '0;
          state_nxt      = ST_EMIT;
        end else if (cmp_idx_r == len_r) begin
          res_status_nxt = STAT_HIT;
          res_width_nxt  = meta_width;
          state_nxt      = ST_EMIT;
        end else begin
          cmp_idx_nxt = LEN_W'(cmp_idx_r + 1'b1);
        end
      end
      ST_COPY: begin
        if (cmp_idx_r == pend_len_r) begin
          state_nxt = ST_IDLE;
        end else begin
          key_we      = 1'b1;
          cmp_idx_nxt = LEN_W'(cmp_idx_r + 1'b1);
        end
      end
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_idx_r;
        meta_wdata = '0;
        if (clr_idx_r == SLOT_W'(SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_idx_nxt = SLOT_W'(clr_idx_r + 1'b1);
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_width_nxt  = res_width_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      hash_r      <= FNV_BASIS;
      key_len_r   <= '0;
      pend_r      <= 1'b0;
      pend_slot_r <= '0;
      pend_size_r <= '0;
      pend_len_r  <= '0;
      cmp_idx_r   <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      key_len_r   <= key_len_nxt;
      pend_r      <= pend_nxt;
      pend_slot_r <= pend_slot_nxt;
      pend_size_r <= pend_size_nxt;
      pend_len_r  <= pend_len_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r       <= byte_nxt;
    last_r       <= last_nxt;
    size_r       <= size_nxt;
    slot_r       <= slot_nxt;
    len_r        <= len_nxt;
    res_status_r <= res_status_nxt;
    res_width_r  <= res_width_nxt;
    out_status_r <= out_status_nxt;
    out_width_r  <= out_width_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_width  = out_width_r;

endmodule

// ===== sv/mmc_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_check: port-level checks of the measure memo cache
// Result beat stability, width on non-hits, busy windows after key, invalidate and reset.
// ----------------------------------------------------------------------------
module mmc_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_operation,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_width
);

  import mmc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_width))
    else $error("result beat changed while stalled");

  a_width_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_HIT |-> out_width == '0)
    else $error("nonzero width on a non-hit result");

  a_key_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_KEY |=> !in_ready)
    else $error("ready right after a key byte");

  a_inval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_INVAL |=> !in_ready)
    else $error("ready right after invalidate");

  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("ready right after reset");

endmodule

bind measure_memo_cache_top mmc_check u_mmc_check (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_operation (in_operation),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_width    (out_width)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: measure memo cache, key hashing, hit/miss/too-long and fills
// A scoreboard class predicts every result from its own copy of the hash,
// the key buffer and the slot store; plain tasks stream keys, fills and
// invalidates with random input gaps and random output back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import mmc_pkg::*;

  localparam int unsigned SLOT_COUNT = 4096;
  localparam int KEY_LIMIT = 32;
  localparam int BUF_BYTES = KEY_LIMIT - 1;
  localparam int KEY_MAX = 40;
  localparam int RANDOM_BEATS = 850;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    status_t status;
    logic signed [WIDTH_W-1:0] width;
  } width_result_t;

  typedef struct {
    bit [BYTE_W-1:0] b [0:KEY_MAX-1];
    int len;
    bit [SIZE_W-1:0] size;
  } key_t;

  class memo_scoreboard;
    bit [HASH_W-1:0] hash;
    int key_len;
    bit [BYTE_W-1:0] key_buf [0:BUF_BYTES-1];
    bit pend;
    int unsigned pend_slot;
    bit [SIZE_W-1:0] pend_size;
    int pend_len;
    bit ent_valid [0:SLOT_COUNT-1];
    bit [SIZE_W-1:0] ent_size [0:SLOT_COUNT-1];
    int ent_len [0:SLOT_COUNT-1];
    logic signed [WIDTH_W-1:0] ent_width [0:SLOT_COUNT-1];
    bit [BYTE_W-1:0] ent_key [0:SLOT_COUNT-1][0:BUF_BYTES-1];
    width_result_t expected [$];
    int fails, hits, misses, longs, fills, invals;

    function new();
      hash = FNV_BASIS;
      key_len = 0;
      pend = 1'b0;
      foreach (ent_valid[i]) ent_valid[i] = 1'b0;
      fails = 0; hits = 0; misses = 0; longs = 0; fills = 0; invals = 0;
    endfunction

    static function bit [HASH_W-1:0] fold(bit [HASH_W-1:0] h, bit [HASH_W-1:0] v);
      bit [HASH_W-1:0] t;
      t = h ^ v;
      return t * FNV_PRIME;
    endfunction

    function void note_input(op_t op, bit [BYTE_W-1:0] kb, bit lb, bit [SIZE_W-1:0] fs,
                             logic signed [WIDTH_W-1:0] fw);
      width_result_t res;
      int unsigned slot;
      int len;
      bit hit;
      case (op)
        OP_KEY: begin
          if (key_len == 0) pend = 1'b0;
          hash = fold(hash, {24'd0, kb});
          if (key_len < BUF_BYTES) key_buf[key_len] = kb;
          if (key_len < KEY_LIMIT) key_len++;
          if (lb) begin
            len = key_len;
            if (len >= KEY_LIMIT) begin
              pend = 1'b0;
              res.status = STAT_LONG;
              res.width = '0;
              longs++;
            end else begin
              slot = fold(hash, {25'd0, fs}) % SLOT_COUNT;
              hit = ent_valid[slot] && ent_size[slot] == fs && ent_len[slot] == len;
              for (int i = 0; hit && i < len; i++)
                if (ent_key[slot][i] != key_buf[i]) hit = 1'b0;
              if (hit) begin
                res.status = STAT_HIT;
                res.width = ent_width[slot];
                hits++;
              end else begin
                pend = 1'b1;
                pend_slot = slot;
                pend_size = fs;
                pend_len = len;
                res.status = STAT_MISS;
                res.width = '0;
                misses++;
              end
            end
            hash = FNV_BASIS;
            key_len = 0;
            expected.push_back(res);
          end
        end
        OP_FILL: begin
          if (pend) begin
            ent_valid[pend_slot] = 1'b1;
            ent_size[pend_slot] = pend_size;
            ent_len[pend_slot] = pend_len;
            ent_width[pend_slot] = fw;
            for (int i = 0; i < pend_len; i++) ent_key[pend_slot][i] = key_buf[i];
            pend = 1'b0;
            fills++;
          end
        end
        OP_INVAL: begin
          foreach (ent_valid[i]) ent_valid[i] = 1'b0;
          pend = 1'b0;
          invals++;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [1:0] status, logic signed [WIDTH_W-1:0] width);
      width_result_t res;
      if (expected.size() == 0) begin
        $error("result beat with nothing expected: status %0d width %0d", status, width);
        fails++;
        return;
      end
      res = expected.pop_front();
      if (status !== res.status) begin
        $error("status mismatch: expected %0d, actual %0d", res.status, status);
        fails++;
      end
      if (width !== res.width) begin
        $error("width mismatch: expected %0d, actual %0d", res.width, width);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_operation;
  logic [BYTE_W-1:0] in_key_byte;
  logic in_last_byte;
  logic [SIZE_W-1:0] in_font_size;
  logic signed [WIDTH_W-1:0] in_fill_width;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic signed [WIDTH_W-1:0] out_width;

  memo_scoreboard sb = new();
  key_t pool [$];
  bit calm;
  int beats_sent;
  int inval_sent;
  int colliders;
  int quiet_cycles;

  measure_memo_cache_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_key_byte  (in_key_byte),
    .in_last_byte (in_last_byte),
    .in_font_size (in_font_size),
    .in_fill_width(in_fill_width),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_width    (out_width)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 29);
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_input(op_t'(in_operation), in_key_byte, in_last_byte, in_font_size,
                      in_fill_width);
      if (out_valid && out_ready) sb.check_result(out_status, out_width);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  function automatic logic signed [WIDTH_W-1:0] rand_width();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'sh8000;
    if (r < 20) return 16'sh7fff;
    return WIDTH_W'($urandom_range(16'hffff));
  endfunction

  function automatic bit [SIZE_W-1:0] rand_size();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return SIZE_W'($urandom_range(127));
  endfunction

  function automatic key_t rand_key(int len);
    key_t k;
    k.len = len;
    k.size = rand_size();
    foreach (k.b[i]) k.b[i] = BYTE_W'($urandom_range(255));
    return k;
  endfunction

  function automatic int unsigned slot_of(key_t k);
    bit [HASH_W-1:0] h;
    h = FNV_BASIS;
    for (int i = 0; i < k.len; i++) h = memo_scoreboard::fold(h, {24'd0, k.b[i]});
    h = memo_scoreboard::fold(h, {25'd0, k.size});
    return h % SLOT_COUNT;
  endfunction

  // entered and left at a falling edge
  task automatic send_beat(op_t op, bit [BYTE_W-1:0] kb, bit lb, bit [SIZE_W-1:0] fs,
                           logic signed [WIDTH_W-1:0] fw);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_key_byte <= kb;
    in_last_byte <= lb;
    in_font_size <= fs;
    in_fill_width <= fw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_key(key_t k, int first, int stop);
    bit lb;
    for (int i = first; i < stop; i++) begin
      lb = (i == k.len - 1);
      send_beat(OP_KEY, k.b[i], lb, lb ? k.size : rand_size(), rand_width());
    end
  endtask

  task automatic send_other(op_t op);
    if (op == OP_INVAL) inval_sent++;
    send_beat(op, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), rand_size(),
              rand_width());
  endtask

  task automatic send_fill();
    send_beat(OP_FILL, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), rand_size(),
              rand_width());
  endtask

  function automatic int rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 6);
    if (r < 90) return $urandom_range(7, 20);
    return $urandom_range(21, BUF_BYTES);
  endfunction

  function automatic int long_len();
    case ($urandom_range(4))
      0: return BUF_BYTES;
      1: return KEY_LIMIT;
      2: return KEY_LIMIT + 1;
      3: return KEY_MAX;
      default: return $urandom_range(BUF_BYTES, KEY_MAX);
    endcase
  endfunction

  initial begin
    key_t k, c;
    int r, cut, tries;
    int unsigned target;
    op_t op;
    calm = 1'b0;
    beats_sent = 0;
    inval_sent = 0;
    colliders = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_NONE;
    in_key_byte = '0;
    in_last_byte = 1'b0;
    in_font_size = '0;
    in_fill_width = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // smallest byte and size, most negative width, then the hit
    k = rand_key(1);
    k.b[0] = 8'h00;
    k.size = '0;
    send_key(k, 0, 1);
    send_beat(OP_FILL, 8'hff, 1'b1, '1, 16'sh8000);
    send_key(k, 0, 1);
    // largest byte and size, most positive width
    c = rand_key(2);
    c.b[0] = 8'hff;
    c.b[1] = 8'h41;
    c.size = '1;
    send_key(c, 0, 2);
    send_beat(OP_FILL, 8'h00, 1'b0, '0, 16'sh7fff);
    send_key(c, 0, 2);
    // stray fill and the unused code
    send_fill();
    send_other(OP_NONE);
    // new key over a pending miss, the fill in between is dropped
    c = rand_key(1);
    c.size = 7'd5;
    send_key(c, 0, 1);
    send_beat(OP_KEY, 8'h77, 1'b0, '0, '0);
    send_fill();
    send_beat(OP_KEY, 8'h88, 1'b1, 7'd5, '0);
    send_key(c, 0, 1);
    // invalidate with a key in progress
    send_beat(OP_KEY, 8'h10, 1'b0, '0, '0);
    send_other(OP_INVAL);
    send_beat(OP_KEY, 8'h20, 1'b1, 7'd9, '0);
    send_key(k, 0, 1);

    while (beats_sent < RANDOM_BEATS) begin
      calm = (beats_sent >= 420 && beats_sent < 560);
      r = $urandom_range(99);
      if (r < 50) begin
        if (pool.size() > 0 && $urandom_range(99) < 60) begin
          k = pool[$urandom_range(pool.size() - 1)];
        end else begin
          k = rand_key(rand_len());
          if (pool.size() < 48) pool.push_back(k);
        end
        send_key(k, 0, k.len);
        if ($urandom_range(99) < 85) send_fill();
      end else if (r < 60) begin
        // different key landing on the slot of a known one
        if (pool.size() == 0) pool.push_back(rand_key(rand_len()));
        k = pool[$urandom_range(pool.size() - 1)];
        target = slot_of(k);
        tries = 0;
        do begin
          c = rand_key((k.len >= 2 && k.len <= 4) ? k.len : $urandom_range(2, 3));
          if ($urandom_range(1)) c.size = k.size;
          tries++;
        end while (slot_of(c) != target && tries < 200000);
        colliders++;
        send_key(c, 0, c.len);
        if ($urandom_range(99) < 70) send_fill();
      end else if (r < 70) begin
        // broken key: something else lands before or between its bytes
        k = (pool.size() > 0 && $urandom_range(1)) ? pool[$urandom_range(pool.size() - 1)]
                                                    : rand_key(rand_len());
        cut = $urandom_range(0, k.len - 1);
        send_key(k, 0, cut);
        case ($urandom_range(2))
          0: send_fill();
          1: send_other(OP_NONE);
          default: send_other((inval_sent < 10 && $urandom_range(99) < 30) ? OP_INVAL
                                                                          : OP_FILL);
        endcase
        send_key(k, cut, k.len);
        if ($urandom_range(99) < 70) send_fill();
      end else if (r < 78) begin
        k = rand_key(long_len());
        send_key(k, 0, k.len);
        if ($urandom_range(1)) send_fill();
      end else if (r < 97) begin
        op = op_t'($urandom_range(3));
        if (op == OP_INVAL && inval_sent >= 10) op = OP_NONE;
        send_other(op);
      end else begin
        send_other(inval_sent < 10 ? OP_INVAL : OP_NONE);
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (sb.expected.size() != 0) @(posedge clk);
    repeat (SLOT_COUNT + 100) @(posedge clk);
    $display("%0d input beats: %0d hits, %0d misses, %0d long keys, %0d colliding keys",
             beats_sent, sb.hits, sb.misses, sb.longs, colliders);
    $display("%0d fills stored, %0d invalidates", sb.fills, sb.invals);
    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mmc_pkg.sv
sv/mmc_ram.sv
sv/measure_memo_cache_top.sv
sv/mmc_check.sv
tb/testbench.sv
